### rtl/core/inhibitory_weight_adapter_macros.svh
// Assertion macros used by the adapter controller.
`ifndef INHIBITORY_WEIGHT_ADAPTER_MACROS_SVH
`define INHIBITORY_WEIGHT_ADAPTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define IWA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define IWA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IWA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define IWA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/iwa_pkg.sv
`default_nettype none
package iwa_pkg;

   // Item operation codes
   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_FIRE   = 3'd1;
   localparam logic [2:0] OP_CLOSE  = 3'd2;
   localparam logic [2:0] OP_MODIFY = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // Register indexes
   localparam logic [2:0] CSR_MOD_RATE  = 3'd0;
   localparam logic [2:0] CSR_AVG_RATE  = 3'd1;
   localparam logic [2:0] CSR_TARGET    = 3'd2;
   localparam logic [2:0] CSR_SCALE     = 3'd3;
   localparam logic [2:0] CSR_WEIGHTED  = 3'd4;
   localparam logic [2:0] CSR_FIRST     = 3'd5;
   localparam logic [2:0] CSR_LAST      = 3'd6;

   localparam int WEIGHT_W   = 16;
   localparam int INDEX_W    = 10;
   localparam int DEV_W      = 18;
   localparam int ACT_W      = 17;
   localparam int SUM_W      = 32;
   localparam int DIVISOR_W  = 27;
   localparam int QUOT_W     = 16;
   localparam int QCNT_W     = 4;
   localparam logic [WEIGHT_W-1:0] SCALE_RESET = 16'd16384;
   localparam logic [INDEX_W-1:0]  LAST_RESET  = 10'd1023;

   typedef struct packed {
      logic capture;
      logic read;
      logic walk;
      logic divset;
      logic div;
      logic act;
      logic mul1;
      logic mul2;
      logic mix;
      logic mod1;
      logic mod2;
      logic emit;
   } iwa_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       rate_zero;
      logic       in_store;
      logic       walk_needed;
      logic       walk_last;
      logic       div_last;
   } iwa_status_type;

endpackage
`default_nettype wire

### rtl/core/inhibitory_weight_adapter.sv
// Inhibitory weight adapter.
// Commands enter on req_operation, req_neuron_index and req_weight_value and
// are taken at a clock edge with start high and busy low. Each command gives
// exactly one result on the rsp_ ports, held for one cycle while rsp_strobe
// is high; the receiver takes it in that cycle and cannot stall it.
// Registers are written through csr_wr_en, csr_index and csr_wdata, one per
// edge; the user must write them only while the block is idle, which the
// block does not enforce. All items pass a read phase; modify then updates
// the weight if the rate is nonzero and the index is in the store, and a
// close with a nonzero rate runs the bit-serial divider and the activity,
// multiply and mix steps, walking a nonempty range first in weighted mode
// through the single read port of the weight memory. A new command may be
// accepted in the cycle the strobe is high.
// Reset restores the register defaults and clears the activity sum,
// deviation and activity; weights are undefined until loaded.
`default_nettype none
module inhibitory_weight_adapter #(
   parameter int NEURON_COUNT = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [2:0]   req_operation,
   input  wire logic [9:0]   req_neuron_index,
   input  wire logic [15:0]  req_weight_value,
   output logic              rsp_strobe,
   output logic [15:0]       rsp_weight_out,
   output logic signed [17:0] rsp_deviation_out,
   output logic [16:0]       rsp_activity_out,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   iwa_pkg::iwa_cmd_type    cmd;
   iwa_pkg::iwa_status_type status;

   iwa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   iwa_dpath #(.NEURON_COUNT(NEURON_COUNT)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_neuron_index  (req_neuron_index),
      .req_weight_value  (req_weight_value),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_weight_out    (rsp_weight_out),
      .rsp_deviation_out (rsp_deviation_out),
      .rsp_activity_out  (rsp_activity_out)
   );
endmodule
`default_nettype wire

### rtl/core/iwa_ram.sv
`default_nettype none
module iwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/iwa_ctrl.sv
`default_nettype none
`include "inhibitory_weight_adapter_macros.svh"
module iwa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_strobe,
   output iwa_pkg::iwa_cmd_type         cmd,
   input  wire iwa_pkg::iwa_status_type status
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_WDRAIN = 4'd3;
   localparam logic [3:0] S_DIVSET = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_ACT    = 4'd6;
   localparam logic [3:0] S_MUL1   = 4'd7;
   localparam logic [3:0] S_MUL2   = 4'd8;
   localparam logic [3:0] S_MIX    = 4'd9;
   localparam logic [3:0] S_MOD1   = 4'd10;
   localparam logic [3:0] S_MOD2   = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ: begin
            unique case (status.op)
               iwa_pkg::OP_CLOSE: begin
                  if (status.rate_zero) state_in = S_EMIT;
                  else if (status.walk_needed) state_in = S_WALK;
                  else state_in = S_DIVSET;
               end
               iwa_pkg::OP_MODIFY: begin
                  if (!status.rate_zero && status.in_store) state_in = S_MOD1;
                  else state_in = S_EMIT;
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_WALK: begin
            if (status.walk_last) state_in = S_WDRAIN;
         end
         S_WDRAIN: state_in = S_DIVSET;
         S_DIVSET: state_in = S_DIV;
         S_DIV: begin
            if (status.div_last) state_in = S_ACT;
         end
         S_ACT:  state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MIX;
         S_MIX:  state_in = S_EMIT;
         S_MOD1: state_in = S_MOD2;
         S_MOD2: state_in = S_EMIT;
         S_EMIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign strobe_in = (state_ff == S_EMIT);

   // Advance state, raise strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   // Decode commands
   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.read    = (state_ff == S_READ);
      cmd.walk    = (state_ff == S_WALK);
      cmd.divset  = (state_ff == S_DIVSET);
      cmd.div     = (state_ff == S_DIV);
      cmd.act     = (state_ff == S_ACT);
      cmd.mul1    = (state_ff == S_MUL1);
      cmd.mul2    = (state_ff == S_MUL2);
      cmd.mix     = (state_ff == S_MIX);
      cmd.mod1    = (state_ff == S_MOD1);
      cmd.mod2    = (state_ff == S_MOD2);
      cmd.emit    = (state_ff == S_EMIT);
   end

   `IWA_ASSERT_NEXT(a_accept_reads, clock, reset, start && !busy, state_ff == S_READ)
   `IWA_ASSERT_NEXT(a_emit_strobes, clock, reset, state_ff == S_EMIT, rsp_strobe && !busy)
   `IWA_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, state_ff == S_IDLE || state_ff == S_READ)
   `IWA_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == S_DIV && status.div_last, state_ff == S_ACT)
endmodule
`default_nettype wire

### rtl/core/iwa_dpath.sv
`default_nettype none
module iwa_dpath #(
   parameter int NEURON_COUNT = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire iwa_pkg::iwa_cmd_type  cmd,
   output iwa_pkg::iwa_status_type    status,
   input  wire logic [2:0]            req_operation,
   input  wire logic [9:0]            req_neuron_index,
   input  wire logic [15:0]           req_weight_value,
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_index,
   input  wire logic [15:0]           csr_wdata,
   output logic [15:0]                rsp_weight_out,
   output logic signed [17:0]         rsp_deviation_out,
   output logic [16:0]                rsp_activity_out
);
   localparam int ADDR_W = $clog2(NEURON_COUNT);

   // Configuration
   logic [15:0] mod_rate_ff, avg_rate_ff, target_ff, scale_ff;
   logic        weighted_ff;
   logic [9:0]  first_ff, last_ff;
   // Item
   logic [2:0]  op_ff;
   logic [9:0]  idx_ff;
   logic [15:0] wv_ff;
   // State
   logic [31:0]        sum_ff, sum_in;
   logic signed [17:0] dev_ff;
   logic [16:0]        last_act_ff;
   logic [15:0]        w_ff;
   // Walk and divide
   logic [9:0]         walk_ptr_ff;
   logic               pend_ff;
   logic [26:0]        acc_ff, cnt_div_ff, divisor_ff;
   logic [27:0]        rem_ff;
   logic [15:0]        quot_ff;
   logic [3:0]         qcnt_ff;
   logic               dzero_ff, dsat_ff;
   // Arithmetic
   logic [18:0]        scaled_ff;
   logic signed [34:0] prod1_ff, mprod_ff;
   logic signed [37:0] prod2_ff;
   // Output
   logic [15:0]        out_w_ff;
   logic signed [17:0] out_dev_ff;
   logic [16:0]        out_act_ff;

   // Memory ports
   logic [31:0]       req_wide, idx_wide, walk_wide;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [15:0]       rd_data, wr_data;
   logic              wr_en;
   logic              idx_in_store, walk_in_store;

   assign req_wide      = 32'(req_neuron_index);
   assign idx_wide      = 32'(idx_ff);
   assign walk_wide     = 32'(walk_ptr_ff);
   assign idx_in_store  = idx_wide < 32'(NEURON_COUNT);
   assign walk_in_store = walk_wide < 32'(NEURON_COUNT);
   assign rd_addr = cmd.walk ? walk_wide[ADDR_W-1:0] : req_wide[ADDR_W-1:0];
   assign wr_addr = idx_wide[ADDR_W-1:0];

   // Read-path values
   logic [15:0]        rd_gated;
   logic               in_range, range_ok;
   logic [31:0]        fire_add;
   logic [32:0]        fire_sum;
   logic [16:0]        act_val;
   logic [27:0]        rem_shift;
   logic               rem_ge;
   logic [32:0]        scale_prod;
   logic signed [19:0] diff;
   logic signed [38:0] mix_sum;
   logic signed [22:0] mix_shr;
   logic signed [17:0] mix_sat;
   logic signed [16:0] mod_delta;
   logic signed [18:0] mod_w;
   logic [15:0]        mod_clamp;

   assign rd_gated = idx_in_store ? rd_data : 16'd0;
   assign in_range = (idx_ff >= first_ff) && (idx_ff <= last_ff);
   assign range_ok = (first_ff <= last_ff);
   assign fire_add = weighted_ff ? 32'(rd_gated) : 32'd1;
   assign fire_sum = {1'b0, sum_ff} + {1'b0, fire_add};

   assign rem_shift = {rem_ff[26:0], 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, divisor_ff};
   assign act_val   = dzero_ff ? 17'd0 : (dsat_ff ? 17'd65536 : {1'b0, quot_ff});

   assign scale_prod = last_act_ff * scale_ff;
   assign diff    = $signed({1'b0, scaled_ff}) - $signed({4'b0, target_ff});
   assign mix_sum = 39'(prod1_ff) + 39'(prod2_ff);
   assign mix_shr = 23'(mix_sum >>> 16);
   always_comb begin
      if (mix_shr > 23'sd131071) mix_sat = 18'sd131071;
      else if (mix_shr < -23'sd131072) mix_sat = -18'sd131072;
      else mix_sat = mix_shr[17:0];
   end

   assign mod_delta = 17'(mprod_ff >>> 18);
   assign mod_w     = $signed({3'b0, w_ff}) + 19'(mod_delta);
   always_comb begin
      if (mod_w < 19'sd0) mod_clamp = 16'd0;
      else if (mod_w > 19'sd65535) mod_clamp = 16'hFFFF;
      else mod_clamp = mod_w[15:0];
   end

   // Store writes: load on read phase, modified weight at the end
   always_comb begin
      wr_en   = 1'b0;
      wr_data = wv_ff;
      if (cmd.read && op_ff == iwa_pkg::OP_LOAD && idx_in_store) begin
         wr_en = 1'b1;
      end else if (cmd.mod2) begin
         wr_en   = 1'b1;
         wr_data = mod_clamp;
      end
   end

   iwa_ram #(.WIDTH(16), .DEPTH(NEURON_COUNT)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Activity sum next value
   always_comb begin
      sum_in = sum_ff;
      if (cmd.read && op_ff == iwa_pkg::OP_FIRE && in_range) begin
         sum_in = fire_sum[32] ? 32'hFFFF_FFFF : fire_sum[31:0];
      end else if (cmd.read && op_ff == iwa_pkg::OP_CLOSE && mod_rate_ff == 16'd0) begin
         sum_in = '0;
      end else if (cmd.mix) begin
         sum_in = '0;
      end
   end

   // Control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_rate_ff <= '0;
         avg_rate_ff <= '0;
         target_ff   <= '0;
         scale_ff    <= iwa_pkg::SCALE_RESET;
         weighted_ff <= 1'b0;
         first_ff    <= '0;
         last_ff     <= iwa_pkg::LAST_RESET;
         sum_ff      <= '0;
         dev_ff      <= '0;
         last_act_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               iwa_pkg::CSR_MOD_RATE: mod_rate_ff <= csr_wdata;
               iwa_pkg::CSR_AVG_RATE: avg_rate_ff <= csr_wdata;
               iwa_pkg::CSR_TARGET:   target_ff   <= csr_wdata;
               iwa_pkg::CSR_SCALE:    scale_ff    <= csr_wdata;
               iwa_pkg::CSR_WEIGHTED: weighted_ff <= csr_wdata[0];
               iwa_pkg::CSR_FIRST:    first_ff    <= csr_wdata[9:0];
               iwa_pkg::CSR_LAST:     last_ff     <= csr_wdata[9:0];
               default: ;
            endcase
         end
         sum_ff  <= sum_in;
         pend_ff <= cmd.walk && walk_in_store;
         if (cmd.act) last_act_ff <= act_val;
         if (cmd.mix) dev_ff <= mix_sat;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         idx_ff <= req_neuron_index;
         wv_ff  <= req_weight_value;
      end
      // Latch the addressed weight, start the range walk
      if (cmd.read) begin
         w_ff        <= (op_ff == iwa_pkg::OP_LOAD) ? (idx_in_store ? wv_ff : 16'd0) : rd_gated;
         walk_ptr_ff <= first_ff;
         acc_ff      <= '0;
         cnt_div_ff  <= range_ok ? 27'(last_ff - first_ff) + 27'd1 : 27'd0;
      end
      if (cmd.walk) walk_ptr_ff <= walk_ptr_ff + 10'd1;
      if (pend_ff) acc_ff <= acc_ff + 27'(rd_data);
      // Set up the divide
      if (cmd.divset) begin
         divisor_ff <= weighted_ff ? acc_ff : cnt_div_ff;
         dzero_ff   <= (weighted_ff ? acc_ff : cnt_div_ff) == 27'd0;
         dsat_ff    <= sum_ff >= 32'(weighted_ff ? acc_ff : cnt_div_ff);
         rem_ff     <= 28'(sum_ff[26:0]);
         qcnt_ff    <= '0;
      end
      // One quotient bit a cycle
      if (cmd.div) begin
         rem_ff  <= rem_ge ? rem_shift - {1'b0, divisor_ff} : rem_shift;
         quot_ff <= {quot_ff[14:0], rem_ge};
         qcnt_ff <= qcnt_ff + 4'd1;
      end
      if (cmd.mul1) begin
         scaled_ff <= scale_prod[32:14];
         prod1_ff  <= $signed({1'b0, avg_rate_ff}) * dev_ff;
      end
      if (cmd.mul2) begin
         prod2_ff <= $signed({1'b0, 17'd65536 - {1'b0, avg_rate_ff}}) * diff;
      end
      if (cmd.mod1) mprod_ff <= $signed({1'b0, mod_rate_ff}) * dev_ff;
      if (cmd.mod2) w_ff <= mod_clamp;
      // Hold the result for its strobe cycle
      if (cmd.emit) begin
         out_w_ff   <= w_ff;
         out_dev_ff <= dev_ff;
         out_act_ff <= last_act_ff;
      end
   end

   assign status.op          = op_ff;
   assign status.rate_zero   = (mod_rate_ff == 16'd0);
   assign status.in_store    = idx_in_store;
   assign status.walk_needed = weighted_ff && range_ok;
   assign status.walk_last   = (walk_ptr_ff == last_ff);
   assign status.div_last    = (qcnt_ff == 4'd15);

   assign rsp_weight_out    = out_w_ff;
   assign rsp_deviation_out = out_dev_ff;
   assign rsp_activity_out  = out_act_ff;
endmodule
`default_nettype wire
